FILE: hw/rtl/awf_pkg.sv
// awf_pkg: shared sizes, register indexes, controller states and the
// command/status structs between the all-ones window finder's controller and datapath
// no dependencies
package awf_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 3;
    // run counts saturate at the top of their width
    localparam int CNT_W    = 9;
    localparam logic [CNT_W-1:0] RUN_SAT = '1;

    localparam logic [CFG_W-1:0] RST_GRID_ROWS = CFG_W'(10);
    localparam logic [CFG_W-1:0] RST_GRID_COLS = CFG_W'(10);
    localparam logic [CFG_W-1:0] RST_WIN_ROWS  = CFG_W'(3);
    localparam logic [CFG_W-1:0] RST_WIN_COLS  = CFG_W'(3);

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_ROWS  = 3'd0,
        REG_GRID_COLS  = 3'd1,
        REG_WIN_ROWS   = 3'd2,
        REG_WIN_COLS   = 3'd3,
        REG_NO_OVERLAP = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_READY,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_COVER_WR
    } awf_state_t;

    typedef struct packed {
        logic fetch;
        logic step;
        logic scan_read;
        logic scan_next;
        logic scan_rewind;
        logic cover_write;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hit;
        logic no_overlap;
        logic overlap;
        logic scan_done;
    } dp_stat_t;

endpackage

FILE: hw/rtl/awf_ctrl.sv
// awf_ctrl: controller state machine of the all-ones window finder
// depends on awf_pkg
module awf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              cfg_wr_en,
    input  awf_pkg::dp_stat_t stat,
    output awf_pkg::dp_cmd_t  cmd
);
    import awf_pkg::*;

    awf_state_t state_reg;
    awf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FETCH;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_READY) && stat.out_free;
        cmd.step   = s_valid && s_ready;
        case (state_reg)
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                // a register write moves the effective column, so read again
                state_next = cfg_wr_en ? ST_FETCH : ST_READY;
            end
            ST_READY: begin
                if (cfg_wr_en) begin
                    state_next = ST_FETCH;
                end else if (cmd.step && stat.hit && stat.no_overlap) begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                cmd.scan_read = 1'b1;
                state_next    = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (stat.overlap) begin
                    state_next = ST_FETCH;
                end else if (stat.scan_done) begin
                    cmd.scan_rewind = 1'b1;
                    state_next      = ST_COVER_WR;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_COVER_WR: begin
                cmd.cover_write = 1'b1;
                if (stat.scan_done) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_FETCH;
            end
        endcase
    end

endmodule

FILE: hw/rtl/awf_datapath.sv
// awf_datapath: configuration registers, grid position, column height and
// cover stores, run counting and the result register
// depends on awf_pkg
module awf_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [awf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [awf_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                       s_pixel,
    input  awf_pkg::dp_cmd_t           cmd,
    output awf_pkg::dp_stat_t          stat,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [awf_pkg::ROW_W-1:0]  m_top_row,
    output logic [awf_pkg::COL_W-1:0]  m_left_col
);
    import awf_pkg::*;

    // configuration
    logic [CFG_W-1:0] grid_rows_reg, grid_cols_reg, win_rows_reg, win_cols_reg;
    logic             no_overlap_reg;

    // position and row run
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [CNT_W-1:0] row_run_reg, row_run_next;

    // column height store, registered read with write bypass
    logic [CNT_W-1:0] ch_mem [MAX_COLS];
    logic [CNT_W-1:0] ch_rd_reg;
    logic             byp_reg;
    logic [CNT_W-1:0] byp_val_reg;
    logic [COL_W-1:0] ch_rd_addr;

    // cover store with one valid bit per column
    logic [CNT_W-1:0]    cov_mem [MAX_COLS];
    logic [CNT_W-1:0]    cov_rd_reg;
    logic                cv_rd_reg;
    logic [MAX_COLS-1:0] cvalid_reg;

    // saved window for the overlap scan
    logic [COL_W-1:0] k_reg;
    logic [COL_W-1:0] last_col_reg;
    logic [CNT_W-1:0] top_sav_reg;
    logic [COL_W-1:0] left_sav_reg;
    logic [CNT_W-1:0] rp1_sav_reg;

    // result register
    logic             m_valid_reg;
    logic [ROW_W-1:0] top_out_reg;
    logic [COL_W-1:0] left_out_reg;

    logic [CFG_W-1:0] rows_eff, cols_eff, wr_eff, wc_eff;
    logic             c_over;
    logic [ROW_W:0]   r_inc;
    logic [ROW_W-1:0] cur_r;
    logic [COL_W-1:0] cur_c;
    logic             grid_start;
    logic [CNT_W-1:0] h_prev, h_new, run_base;
    logic [CNT_W-1:0] top_w, left_w;
    logic             hit;
    logic [COL_W:0]   c_inc;
    logic [ROW_W:0]   r_step;
    logic             wrap_c;
    logic             load_direct;

    always_comb begin
        rows_eff = (grid_rows_reg == '0) ? CFG_W'(1) :
                   (grid_rows_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : grid_rows_reg;
        cols_eff = (grid_cols_reg == '0) ? CFG_W'(1) :
                   (grid_cols_reg > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_cols_reg;
        wr_eff   = (win_rows_reg == '0) ? CFG_W'(1) : win_rows_reg;
        wc_eff   = (win_cols_reg == '0) ? CFG_W'(1) : win_cols_reg;

        // position of this pixel, folded back into a grid that may have shrunk
        c_over = {1'b0, col_pos_reg} >= cols_eff;
        r_inc  = c_over ? {1'b0, row_pos_reg} + 1'b1 : {1'b0, row_pos_reg};
        cur_c  = c_over ? '0 : col_pos_reg;
        cur_r  = (CFG_W'(r_inc) >= rows_eff) ? '0 : r_inc[ROW_W-1:0];
        grid_start = (cur_r == '0) && (cur_c == '0);

        h_prev = byp_reg ? byp_val_reg : ch_rd_reg;
        if (!s_pixel) begin
            h_new = '0;
        end else if (cur_r == '0) begin
            h_new = CNT_W'(1);
        end else begin
            h_new = (h_prev == RUN_SAT) ? h_prev : h_prev + 1'b1;
        end

        run_base = (cur_c == '0) ? '0 : row_run_reg;
        if (h_new >= wr_eff) begin
            row_run_next = (run_base == RUN_SAT) ? run_base : run_base + 1'b1;
        end else begin
            row_run_next = '0;
        end
        hit = row_run_next >= wc_eff;

        top_w  = CNT_W'({1'b0, cur_r}) + 1'b1 - wr_eff;
        left_w = CNT_W'({1'b0, cur_c}) + 1'b1 - wc_eff;

        // position after this pixel
        c_inc  = {1'b0, cur_c} + 1'b1;
        wrap_c = CFG_W'(c_inc) >= cols_eff;
        col_pos_next = wrap_c ? '0 : c_inc[COL_W-1:0];
        r_step = wrap_c ? {1'b0, cur_r} + 1'b1 : {1'b0, cur_r};
        row_pos_next = (CFG_W'(r_step) >= rows_eff) ? '0 : r_step[ROW_W-1:0];

        ch_rd_addr  = cmd.fetch ? cur_c : col_pos_next;
        load_direct = cmd.step && hit && !no_overlap_reg;

        stat.out_free   = !m_valid_reg || m_ready;
        stat.hit        = hit;
        stat.no_overlap = no_overlap_reg;
        stat.overlap    = cv_rd_reg && (cov_rd_reg > top_sav_reg);
        stat.scan_done  = k_reg == last_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg  <= RST_GRID_ROWS;
            grid_cols_reg  <= RST_GRID_COLS;
            win_rows_reg   <= RST_WIN_ROWS;
            win_cols_reg   <= RST_WIN_COLS;
            no_overlap_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_GRID_ROWS:  grid_rows_reg  <= cfg_wr_data;
                REG_GRID_COLS:  grid_cols_reg  <= cfg_wr_data;
                REG_WIN_ROWS:   win_rows_reg   <= cfg_wr_data;
                REG_WIN_COLS:   win_cols_reg   <= cfg_wr_data;
                REG_NO_OVERLAP: no_overlap_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            row_run_reg <= '0;
            byp_reg     <= 1'b0;
            cvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.step) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
                row_run_reg <= row_run_next;
            end
            if (cmd.fetch || cmd.step) begin
                // one-column grid reads back the column just written
                byp_reg <= cmd.step && (col_pos_next == cur_c);
            end
            if (cmd.step && grid_start) begin
                cvalid_reg <= '0;
            end else if (cmd.cover_write) begin
                cvalid_reg[k_reg] <= 1'b1;
            end
            if (load_direct || cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            ch_mem[cur_c] <= h_new;
            byp_val_reg   <= h_new;
        end
        if (cmd.fetch || cmd.step) begin
            ch_rd_reg <= ch_mem[ch_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cover_write) begin
            cov_mem[k_reg] <= rp1_sav_reg;
        end
        if (cmd.scan_read) begin
            cov_rd_reg <= cov_mem[k_reg];
            cv_rd_reg  <= cvalid_reg[k_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            k_reg        <= left_w[COL_W-1:0];
            left_sav_reg <= left_w[COL_W-1:0];
            last_col_reg <= cur_c;
            top_sav_reg  <= top_w;
            rp1_sav_reg  <= CNT_W'({1'b0, cur_r}) + 1'b1;
        end else if (cmd.scan_rewind) begin
            k_reg <= left_sav_reg;
        end else if (cmd.scan_next) begin
            k_reg <= k_reg + 1'b1;
        end
        if (load_direct) begin
            top_out_reg  <= top_w[ROW_W-1:0];
            left_out_reg <= left_w[COL_W-1:0];
        end else if (cmd.emit) begin
            top_out_reg  <= top_sav_reg[ROW_W-1:0];
            left_out_reg <= left_sav_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_top_row  = top_out_reg;
    assign m_left_col = left_out_reg;

endmodule

FILE: hw/rtl/all_ones_window_finder_top.sv
// all_ones_window_finder_top: top level, joins controller and datapath
// depends on awf_pkg, awf_ctrl, awf_datapath
// result: registered with its pixel, or with no_overlap after a read and compare then a write per window column
// throughput: one pixel per cycle while the result register drains; a fetch state after reset or a register
// write holds input, as do a no_overlap window's column reads, compares, writes and refetch
// reset: position, run count, cover store and output cleared, registers to defaults
module all_ones_window_finder_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [awf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [awf_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_pixel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [awf_pkg::ROW_W-1:0]  m_top_row,
    output logic [awf_pkg::COL_W-1:0]  m_left_col
);
    import awf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    awf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_wr_en (cfg_wr_en),
        .stat      (stat),
        .cmd       (cmd)
    );

    awf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_pixel     (s_pixel),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_row   (m_top_row),
        .m_left_col  (m_left_col)
    );

endmodule

FILE: tb/tb_all_ones_window_finder_top.sv
// tb_all_ones_window_finder_top: self-checking bench for the all-ones window finder,
// a behavioural corner predictor, directed grids then random grids, both sides throttled
// depends on awf_pkg and all_ones_window_finder_top
`timescale 1ns / 100ps

module tb_all_ones_window_finder_top;
    import awf_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] top_row;
        logic [COL_W-1:0] left_col;
    } corner_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_RARE_STALL,
        RX_EVERY_THIRD
    } rx_mode_t;

    localparam int TARGET_PIXELS = 1850;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [IDX_W-1:0]   cfg_index   = REG_GRID_ROWS;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_pixel     = 1'b0;
    logic               m_ready     = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [ROW_W-1:0]   m_top_row;
    logic [COL_W-1:0]   m_left_col;

    all_ones_window_finder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_row   (m_top_row),
        .m_left_col  (m_left_col)
    );

    always #6 aclk = ~aclk;

    // predictor copy of the registers and scan state
    logic [CFG_W-1:0] grid_rows_q  = RST_GRID_ROWS;
    logic [CFG_W-1:0] grid_cols_q  = RST_GRID_COLS;
    logic [CFG_W-1:0] win_rows_q   = RST_WIN_ROWS;
    logic [CFG_W-1:0] win_cols_q   = RST_WIN_COLS;
    logic             no_overlap_q = 1'b0;
    int unsigned      at_row = 0;
    int unsigned      at_col = 0;
    logic [CNT_W-1:0] ones_above [MAX_COLS];
    logic [CNT_W-1:0] wide_run = '0;
    logic [CNT_W-1:0] covered_to [MAX_COLS];

    corner_t expected_corners [$];

    int pixels_sent     = 0;
    int corners_checked = 0;
    int grids_started   = 0;
    int fail_count      = 0;

    // sender and receiver throttling
    int burst_left   = 0;
    int gap_max      = 0;
    int hold_len     = 0;
    int hold_req_cnt = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int mode_left    = 0;
    int third_cnt    = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    initial begin
        foreach (ones_above[k]) ones_above[k] = '0;
        foreach (covered_to[k]) covered_to[k] = '0;
    end

    function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic random_pixel(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void find_windows_at_pixel(logic p);
        int unsigned rows, cols, wr, wc, top, left, k;
        logic [CNT_W-1:0] h;
        logic keep;
        corner_t hit;
        rows = eff_size(grid_rows_q, MAX_ROWS);
        cols = eff_size(grid_cols_q, MAX_COLS);
        wr = (win_rows_q == 0) ? 1 : win_rows_q;
        wc = (win_cols_q == 0) ? 1 : win_cols_q;
        // a position left beyond a shrunk grid wraps first
        if (at_col >= cols) begin
            at_col = 0;
            at_row++;
        end
        if (at_row >= rows) at_row = 0;
        if (at_row == 0 && at_col == 0) begin
            foreach (covered_to[i]) covered_to[i] = '0;
        end
        h = (at_row == 0) ? '0 : ones_above[at_col];
        if (p) h = (h != RUN_SAT) ? h + 1'b1 : h;
        else h = '0;
        ones_above[at_col] = h;
        if (at_col == 0) wide_run = '0;
        if (h >= wr) wide_run = (wide_run != RUN_SAT) ? wide_run + 1'b1 : wide_run;
        else wide_run = '0;
        if (wide_run >= wc) begin
            top  = at_row + 1 - wr;
            left = at_col + 1 - wc;
            keep = 1'b1;
            if (no_overlap_q) begin
                for (k = left; k <= at_col && keep; k++)
                    if (covered_to[k] > top) keep = 1'b0;
                if (keep)
                    for (k = left; k <= at_col; k++) covered_to[k] = CNT_W'(at_row + 1);
            end
            if (keep) begin
                hit.top_row  = top[ROW_W-1:0];
                hit.left_col = left[COL_W-1:0];
                expected_corners.insert(expected_corners.size(), hit);
            end
        end
        at_col++;
        if (at_col >= cols) begin
            at_col = 0;
            at_row++;
            if (at_row >= rows) at_row = 0;
        end
    endfunction

    // register writes, accepted pixels and returned corners, all sampled at the edge
    always @(posedge aclk) begin
        corner_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    REG_GRID_ROWS:  grid_rows_q  = cfg_wr_data;
                    REG_GRID_COLS:  grid_cols_q  = cfg_wr_data;
                    REG_WIN_ROWS:   win_rows_q   = cfg_wr_data;
                    REG_WIN_COLS:   win_cols_q   = cfg_wr_data;
                    REG_NO_OVERLAP: no_overlap_q = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) find_windows_at_pixel(s_pixel);
            if (m_valid && m_ready) begin
                corners_checked++;
                if (expected_corners.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected corner row %0d col %0d", m_top_row, m_left_col);
                end else begin
                    want = expected_corners.pop_front();
                    if (want.top_row !== m_top_row || want.left_col !== m_left_col) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("corner mismatch: expected row %0d col %0d, got row %0d col %0d",
                                     want.top_row, want.left_col, m_top_row, m_left_col);
                    end
                end
            end
        end
    end

    // receiver: changes its stall pattern now and then, long hold-off on request
    always @(posedge aclk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:     m_ready <= 1'b1;
                RX_COIN:       m_ready <= 1'($urandom_range(0, 1));
                RX_RARE_STALL: m_ready <= ($urandom_range(0, 7) != 0);
                default: begin
                    third_cnt++;
                    m_ready <= (third_cnt % 3 != 0);
                end
            endcase
        end
    end

    task automatic send_pixel(logic p);
        int gap;
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_pixels(int n, int pct);
        repeat (n) send_pixel(random_pixel(pct));
    endtask

    // block idle: nothing owed, then long enough for a silent cover scan to finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_corners.size() != 0) @(posedge aclk);
        repeat (3 * win_cols_q + 20) @(posedge aclk);
    endtask

    task automatic set_config(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                              logic [CFG_W-1:0] wr, logic [CFG_W-1:0] wc, logic novl);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GRID_ROWS;  cfg_wr_data <= rows; @(posedge aclk);
        cfg_index <= REG_GRID_COLS;  cfg_wr_data <= cols; @(posedge aclk);
        cfg_index <= REG_WIN_ROWS;   cfg_wr_data <= wr;   @(posedge aclk);
        cfg_index <= REG_WIN_COLS;   cfg_wr_data <= wc;   @(posedge aclk);
        // upper bits of the flag write are don't-care
        cfg_index <= REG_NO_OVERLAP;
        cfg_wr_data <= {8'($urandom_range(0, 255)), novl};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // finish any partial grid under the old settings, then load the new ones
    task automatic start_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                              logic [CFG_W-1:0] wr, logic [CFG_W-1:0] wc, logic novl);
        int unsigned r, c, nr, nc, left_over;
        wait_idle();
        nr = eff_size(grid_rows_q, MAX_ROWS);
        nc = eff_size(grid_cols_q, MAX_COLS);
        r = at_row;
        c = at_col;
        if (c >= nc) begin
            c = 0;
            r++;
        end
        if (r >= nr) r = 0;
        left_over = (r == 0 && c == 0) ? 0 : nr * nc - (r * nc + c);
        if (left_over != 0) begin
            send_pixels(left_over, 50);
            wait_idle();
        end
        set_config(rows, cols, wr, wc, novl);
        gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        grids_started++;
    endtask

    // one full 256-wide row, clamped from 511; also fills every column height entry
    task automatic test_full_width_row();
        start_grid(9'd0, 9'd511, 9'd1, 9'd1, 1'b0);
        for (int i = 0; i < MAX_COLS; i++) send_pixel(i == MAX_COLS - 1 ? 1'b1 : random_pixel(70));
    endtask

    task automatic test_tall_column();
        start_grid(9'd300, 9'd1, 9'd1, 9'd1, 1'b1);
        for (int i = 0; i < MAX_ROWS; i++) send_pixel(i == MAX_ROWS - 1 ? 1'b1 : random_pixel(70));
        // tallest window, hit only at the bottom row
        start_grid(9'd256, 9'd1, 9'd256, 9'd1, 1'b0);
        send_pixels(MAX_ROWS, 100);
    endtask

    // zero sizes act as one: every pixel is a grid of its own with a fresh cover store
    task automatic test_zero_sizes();
        start_grid(9'd0, 9'd0, 9'd0, 9'd0, 1'b1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
    endtask

    task automatic test_window_too_big();
        start_grid(9'd2, 9'd2, 9'd3, 9'd1, 1'b0);
        send_pixels(4, 100);
        start_grid(9'd2, 9'd2, 9'd1, 9'd256, 1'b0);
        send_pixels(4, 100);
    endtask

    task automatic test_greedy_cover();
        start_grid(9'd3, 9'd4, 9'd2, 9'd2, 1'b1);
        send_pixels(12, 100);
    endtask

    // grid shrinks under a running position: column wrap, then row wrap to a new grid
    task automatic test_mid_grid_resize();
        start_grid(9'd4, 9'd4, 9'd1, 9'd1, 1'b0);
        send_pixels(6, 100);
        wait_idle();
        set_config(9'd4, 9'd2, 9'd1, 9'd1, 1'b0);
        send_pixels(3, 100);
        wait_idle();
        set_config(9'd2, 9'd2, 9'd1, 9'd1, 1'b1);
        send_pixels(3, 100);
    endtask

    task automatic test_output_backpressure();
        start_grid(9'd4, 9'd8, 9'd1, 9'd1, 1'b0);
        gap_max = 0;
        hold_len = 300;
        hold_req_cnt++;
        send_pixels(32, 100);
        // sender holds until every corner is back
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_corners.size() != 0) @(posedge aclk);
        send_pixels(32, 80);
    endtask

    task automatic test_random_grids();
        logic [CFG_W-1:0] rows, cols, wr, wc;
        int pct, n;
        while (pixels_sent < TARGET_PIXELS) begin
            rows = ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 8));
            cols = ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
            wr   = 9'($urandom_range(0, 4));
            wc   = 9'($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0) wr = rows + 9'd1;
            case ($urandom_range(0, 2))
                0: pct = 50;
                1: pct = 80;
                default: pct = 95;
            endcase
            start_grid(rows, cols, wr, wc, 1'($urandom_range(0, 1)));
            n = eff_size(rows, MAX_ROWS) * eff_size(cols, MAX_COLS);
            if ($urandom_range(0, 7) == 0) begin
                // window or overlap mode changes part way through the grid
                send_pixels(n / 2, pct);
                wait_idle();
                set_config(rows, cols, 9'($urandom_range(0, 4)), 9'($urandom_range(0, 5)),
                           1'($urandom_range(0, 1)));
                send_pixels(n - n / 2, pct);
            end else begin
                send_pixels(n, pct);
            end
        end
    endtask

    initial begin
        int spin;
        int missing;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_full_width_row();
        test_tall_column();
        test_zero_sizes();
        test_window_too_big();
        test_greedy_cover();
        test_mid_grid_resize();
        test_output_backpressure();
        test_random_grids();
        s_valid <= 1'b0;
        spin = 0;
        while (expected_corners.size() != 0 && spin < 50000) begin
            @(posedge aclk);
            spin++;
        end
        repeat (3 * win_cols_q + 20) @(posedge aclk);
        missing = expected_corners.size();
        if (missing != 0) begin
            $display("%0d expected corners never arrived", missing);
        end
        $display("ran %0d pixels over %0d grid settings, %0d corners returned, %0d errors",
                 pixels_sent, grids_started, corners_checked, fail_count + missing);
        $display("size clamps, zero and oversize windows, greedy cover and output stalls exercised");
        if (fail_count + missing == 0) begin
            $display("tb_all_ones_window_finder_top passed");
        end else begin
            $display("tb_all_ones_window_finder_top failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_all_ones_window_finder_top failed");
        $finish;
    end

endmodule
